// ===== sv/spq_pkg.sv =====
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 16;
  localparam int DATA_BITS = 32;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_TOP   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Shift controls broadcast to every cell
  typedef struct packed {
    logic push;  // insert new entry, cells at and above the slot shift up
    logic pop;   // every cell takes its upper neighbour
  } spq_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
module spq_cell
  import spq_pkg::*;
(
  input  logic                 clk,
  input  spq_ctrl_t            ctrl,
  input  logic                 occupied,
  input  logic [DATA_BITS-1:0] new_data,
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic                 lower_take,
  input  logic [DATA_BITS-1:0] lower_data,
  input  logic [PRIO_BITS-1:0] lower_prio,
  input  logic [DATA_BITS-1:0] upper_data,
  input  logic [PRIO_BITS-1:0] upper_prio,
  output logic                 take,
  output logic [DATA_BITS-1:0] data,
  output logic [PRIO_BITS-1:0] prio
);

  // Strictly greater keeps equal priorities in arrival order
  assign take = !occupied || (prio > new_prio);

  always_ff @(posedge clk) begin
    if (ctrl.push && take) begin
      if (lower_take) begin
        data <= lower_data;
        prio <= lower_prio;
      end else begin
        data <= new_data;
        prio <= new_prio;
      end
    end else if (ctrl.pop) begin
      data <= upper_data;
      prio <= upper_prio;
    end
  end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue, smallest priority first, DEPTH entries.
// Command channel: a transfer happens on a rising edge with start high and
// busy low. busy is held low, so a command may be issued every cycle.
// command selects push (item_data, item_priority), pop, top or clear.
// Result channel: exactly one result per command, shown for one cycle with
// done high, in the cycle after the command transfer (one
// command per cycle). The receiver cannot stall; results must be taken.
// head_data/head_priority carry the head for a good pop or top, else zero.
// status: ok, empty (pop/top on an empty queue) or full (push dropped).
// occupancy is the entry count after the command.
// Storage is a row of cells; each compares the new priority with its own
// in parallel and either keeps, takes its lower neighbour, takes the new
// item (push) or takes its upper neighbour (pop).
// Reset empties the queue (count to zero) and clears done; cell contents
// are left as they are and only entries below the count are ever read.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command,
  input  logic signed [DATA_BITS-1:0] item_data,
  input  logic [PRIO_BITS-1:0]        item_priority,
  output logic                        done,
  output logic signed [DATA_BITS-1:0] head_data,
  output logic [PRIO_BITS-1:0]        head_priority,
  output logic [1:0]                  status,
  output logic [CNT_BITS-1:0]         occupancy
);

  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  count_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  spq_ctrl_t            ctrl;

  logic                 cell_take [DEPTH];
  logic [DATA_BITS-1:0] cell_data [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_BITS'(DEPTH));
  assign empty  = (count == '0);

  assign ctrl.push = accept && (command == CMD_PUSH) && !full;
  assign ctrl.pop  = accept && (command == CMD_POP) && !empty;

  // Row of cells; cell 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 lo_take;
    logic [DATA_BITS-1:0] lo_data;
    logic [PRIO_BITS-1:0] lo_prio;
    logic [DATA_BITS-1:0] up_data;
    logic [PRIO_BITS-1:0] up_prio;

    if (i == 0) begin : g_first
      assign lo_take = 1'b0;
      assign lo_data = item_data;
      assign lo_prio = item_priority;
    end else begin : g_mid
      assign lo_take = cell_take[i-1];
      assign lo_data = cell_data[i-1];
      assign lo_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign up_data = cell_data[i];
      assign up_prio = cell_prio[i];
    end else begin : g_inner
      assign up_data = cell_data[i+1];
      assign up_prio = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CNT_BITS'(i) < count),
      .new_data   (item_data),
      .new_prio   (item_priority),
      .lower_take (lo_take),
      .lower_data (lo_data),
      .lower_prio (lo_prio),
      .upper_data (up_data),
      .upper_prio (up_prio),
      .take       (cell_take[i]),
      .data       (cell_data[i]),
      .prio       (cell_prio[i])
    );
  end

  // Entry count update
  always_comb begin
    count_next = count;
    if (accept) begin
      case (command)
        CMD_PUSH:  if (!full)  count_next = count + 1'b1;
        CMD_POP:   if (!empty) count_next = count - 1'b1;
        CMD_CLEAR: count_next = '0;
        default:   count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result register; head is read before the shift lands
  always_ff @(posedge clk) begin
    if (accept) begin
      head_data     <= '0;
      head_priority <= '0;
      status        <= ST_OK;
      occupancy     <= count_next;
      if (command inside {CMD_POP, CMD_TOP}) begin
        if (empty) begin
          status <= ST_EMPTY;
        end else begin
          head_data     <= $signed(cell_data[0]);
          head_priority <= cell_prio[0];
        end
      end else if (command == CMD_PUSH && full) begin
        status <= ST_FULL;
      end
    end
  end

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> occupancy <= CNT_BITS'(DEPTH))
    else $error("occupancy beyond depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_PUSH && full |=>
      done && status == ST_FULL && occupancy == CNT_BITS'(DEPTH))
    else $error("push into full queue not flagged");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_CLEAR |=> done && occupancy == '0 && count == '0)
    else $error("clear did not empty queue");

  a_empty_res: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> occupancy == '0 && head_data == '0
      && head_priority == '0)
    else $error("empty result inconsistent");

endmodule

// ===== dv/tb_sorted_priority_queue.sv =====
module tb_sorted_priority_queue;
  import spq_pkg::*;

  // Generous ceiling on run length
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles to wait once the last expected result is in, to catch stray strobes
  localparam int DRAIN_CYCLES = 4;

  // One result as the block should present it
  typedef struct {
    logic signed [DATA_BITS-1:0] head_data;
    logic [PRIO_BITS-1:0]        head_priority;
    logic [1:0]                  status;
    logic [CNT_BITS-1:0]         occupancy;
  } head_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic [1:0]                  command = CMD_PUSH;
  logic signed [DATA_BITS-1:0] item_data = '0;
  logic [PRIO_BITS-1:0]        item_priority = '0;
  logic                        busy;
  logic                        done;
  logic signed [DATA_BITS-1:0] head_data;
  logic [PRIO_BITS-1:0]        head_priority;
  logic [1:0]                  status;
  logic [CNT_BITS-1:0]         occupancy;

  // Our own copy of the sorted store, head at index 0
  logic signed [DATA_BITS-1:0] model_data [DEPTH];
  logic [PRIO_BITS-1:0]        model_prio [DEPTH];
  int                          model_count = 0;

  head_result_t pending_results[$];

  int error_count    = 0;
  int commands_sent  = 0;
  int results_seen   = 0;
  int full_hits      = 0;
  int empty_hits     = 0;
  int cycle_count    = 0;

  sorted_priority_queue dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .item_data     (item_data),
    .item_priority (item_priority),
    .done          (done),
    .head_data     (head_data),
    .head_priority (head_priority),
    .status        (status),
    .occupancy     (occupancy)
  );

  always #5 clk = ~clk;

  // Apply one accepted command to the model and queue the result it implies.
  // Pushes go after every entry of lower or equal priority, so ties keep
  // arrival order.
  task automatic queue_model_apply(input logic [1:0] cmd,
                                   input logic signed [DATA_BITS-1:0] data,
                                   input logic [PRIO_BITS-1:0] prio);
    head_result_t res;
    int           slot;
    res.head_data     = '0;
    res.head_priority = '0;
    res.status        = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (model_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < model_count && model_prio[slot] <= prio) slot++;
          for (int i = model_count; i > slot; i--) begin
            model_data[i] = model_data[i-1];
            model_prio[i] = model_prio[i-1];
          end
          model_data[slot] = data;
          model_prio[slot] = prio;
          model_count++;
        end
      end
      CMD_POP, CMD_TOP: begin
        if (model_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.head_data     = model_data[0];
          res.head_priority = model_prio[0];
          if (cmd == CMD_POP) begin
            for (int i = 0; i + 1 < model_count; i++) begin
              model_data[i] = model_data[i+1];
              model_prio[i] = model_prio[i+1];
            end
            model_count--;
          end
        end
      end
      default: begin
        model_count = 0;
      end
    endcase
    res.occupancy = model_count[CNT_BITS-1:0];
    pending_results.push_back(res);
  endtask

  // Present one command and hold it until the transfer edge. start is left
  // high so that back-to-back commands need no second assignment in a step.
  task automatic send_command(input logic [1:0] cmd,
                              input logic signed [DATA_BITS-1:0] data,
                              input logic [PRIO_BITS-1:0] prio);
    start         <= 1'b1;
    command       <= cmd;
    item_data     <= data;
    item_priority <= prio;
    do @(posedge clk); while (busy);
    queue_model_apply(cmd, data, prio);
    commands_sent++;
  endtask

  // Sender gap: drop start and scramble the idle fields,
  // which the block must ignore
  task automatic sender_gap(input int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start         <= 1'b0;
      command       <= 2'($urandom);
      item_data     <= $urandom;
      item_priority <= PRIO_BITS'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("ERROR at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Results are sampled at the edge that ends their cycle; the block cannot
  // be stalled, so every strobe must match the oldest expectation
  always @(posedge clk) begin : check_results
    head_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status, -1);
      end else begin
        want = pending_results.pop_front();
        if (want.status == ST_FULL)  full_hits++;
        if (want.status == ST_EMPTY) empty_hits++;
        if (head_data !== want.head_data)
          report_mismatch("head_data", head_data, want.head_data);
        if (head_priority !== want.head_priority)
          report_mismatch("head_priority", head_priority, want.head_priority);
        if (status !== want.status)
          report_mismatch("status", status, want.status);
        if (occupancy !== want.occupancy)
          report_mismatch("occupancy", occupancy, want.occupancy);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Pop and top on an empty queue
  task automatic test_empty_errors();
    send_command(CMD_POP, 32'sd1, 16'd1);
    send_command(CMD_TOP, -32'sd1, 16'hFFFF);
  endtask

  // Payload and priority extremes, plus ties leaving in arrival order
  task automatic test_extremes_and_ties();
    send_command(CMD_PUSH, 32'sh7FFF_FFFF, 16'hFFFF);
    send_command(CMD_PUSH, 32'sh8000_0000, 16'h0000);
    send_command(CMD_PUSH, 32'sd5, 16'h0000);
    send_command(CMD_TOP, '0, '0);
    send_command(CMD_POP, '0, '0);
    send_command(CMD_POP, '0, '0);
    send_command(CMD_POP, '0, '0);
  endtask

  // Fill in descending priority order so each push lands at the head,
  // overflow once, then clear
  task automatic test_full_and_clear();
    for (int i = 0; i < DEPTH; i++)
      send_command(CMD_PUSH, $urandom, PRIO_BITS'(DEPTH - i));
    send_command(CMD_PUSH, 32'sd99, 16'd0);
    send_command(CMD_CLEAR, $urandom, PRIO_BITS'($urandom));
  endtask

  // Random traffic in bursts of fill, drain or mixed bias so the store
  // swings between empty and full; priorities lean small to force ties
  task automatic test_random_traffic(input int n_items, input int idle_pct);
    int          bias;
    int          r;
    int          pick;
    logic [1:0]  cmd;
    logic [PRIO_BITS-1:0] prio;
    bias = 0;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) bias = $urandom_range(2);
      r = $urandom_range(99);
      case (bias)
        0:       cmd = (r < 3) ? CMD_CLEAR : (r < 73) ? CMD_PUSH :
                       (r < 88) ? CMD_POP : CMD_TOP;
        1:       cmd = (r < 2) ? CMD_CLEAR : (r < 22) ? CMD_PUSH :
                       (r < 82) ? CMD_POP : CMD_TOP;
        default: cmd = (r < 4) ? CMD_CLEAR : (r < 50) ? CMD_PUSH :
                       (r < 80) ? CMD_POP : CMD_TOP;
      endcase
      pick = $urandom_range(9);
      if (pick < 5)      prio = PRIO_BITS'($urandom_range(7));
      else if (pick < 8) prio = PRIO_BITS'($urandom_range(16'hFFFF));
      else               prio = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      send_command(cmd, $urandom, prio);
      sender_gap(idle_pct);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_errors();
    test_extremes_and_ties();
    test_full_and_clear();

    // No idling, heavy sender gaps, light sender gaps, then no idling again
    test_random_traffic(425, 0);
    test_random_traffic(425, 62);
    test_random_traffic(425, 18);
    test_random_traffic(425, 0);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands and %0d results: push, pop, top, clear under 0/62/18%% gaps",
             commands_sent, results_seen);
    $display("Full pushes dropped: %0d, empty pops/tops: %0d, mismatches: %0d",
             full_hits, empty_hits, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
